// ===== sv/sfle_pkg.sv =====
//------------------------------------------------------------------------------
// sfle_pkg
// Types and constants shared by the serial frame link engine.
//------------------------------------------------------------------------------
`default_nettype none

package sfle_pkg;

  localparam logic [1:0] REQ_BYTE   = 2'd0;
  localparam logic [1:0] REQ_SUBMIT = 2'd1;
  localparam logic [1:0] REQ_TICK   = 2'd2;

  localparam logic CFG_ACK_TIMEOUT  = 1'b0;
  localparam logic CFG_MAX_ATTEMPTS = 1'b1;

  localparam logic [15:0] ACK_TIMEOUT_RST  = 16'd1000;
  localparam logic [2:0]  MAX_ATTEMPTS_RST = 3'd3;

  localparam logic [7:0] CODE_SOF  = 8'h01;
  localparam logic [7:0] CODE_ACK  = 8'h06;
  localparam logic [7:0] CODE_NACK = 8'h15;
  localparam logic [7:0] CODE_CAN  = 8'h18;

  localparam logic [7:0] KIND_REQUEST  = 8'h00;
  localparam logic [7:0] KIND_RESPONSE = 8'h01;

  localparam logic [7:0] CHECK_INIT      = 8'hFF;
  localparam logic [7:0] MIN_FRAME_LEN   = 8'd3;
  localparam logic [7:0] MIN_PAYLOAD_LEN = 8'd4;
  localparam logic [7:0] LEN_OVERHEAD    = 8'd2;
  localparam logic [7:0] ID_FIRST        = 8'd1;
  localparam logic [7:0] ID_LAST         = 8'hFF;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LEN,
    PH_TYPE,
    PH_BODY,
    PH_CHECK
  } phase_t;

  typedef enum logic [3:0] {
    EV_BODY           = 4'd0,
    EV_RESP_DONE      = 4'd1,
    EV_RESP_AWAIT_CB  = 4'd2,
    EV_CB_DONE        = 4'd3,
    EV_UNSOLICITED    = 4'd4,
    EV_IGNORED        = 4'd5,
    EV_BAD_FRAME      = 4'd6,
    EV_ACK            = 4'd7,
    EV_RESEND         = 4'd8,
    EV_GIVEUP_NACK    = 4'd9,
    EV_GIVEUP_TIMEOUT = 4'd10,
    EV_CAN            = 4'd11,
    EV_ACCEPTED       = 4'd12,
    EV_BUSY           = 4'd13,
    EV_UNKNOWN        = 4'd14
  } ev_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] rx_byte;
    logic [7:0] req_function;
    logic       req_wants_callback;
  } item_t;

  typedef struct packed {
    ev_t        event_res;
    logic [7:0] data_byte;
    logic [7:0] position;
    logic       frame_is_response;
    logic [7:0] func_id;
  } res_t;

endpackage

`default_nettype wire

// ===== sv/sfle_in_stage.sv =====
//------------------------------------------------------------------------------
// sfle_in_stage
// Input register: holds one item until the core consumes it.
//------------------------------------------------------------------------------
`default_nettype none

module sfle_in_stage (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire sfle_pkg::item_t in_item,
  input  wire logic           consume,
  output logic                item_valid,
  output sfle_pkg::item_t     item
);

  logic            valid_r;
  logic            valid_nxt;
  sfle_pkg::item_t item_r;

  assign in_stall   = valid_r && !consume;
  assign valid_nxt  = in_stall ? valid_r : in_valid;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r <= in_item;
    end
  end

endmodule

`default_nettype wire

// ===== sv/sfle_core.sv =====
//------------------------------------------------------------------------------
// sfle_core
// Frame parser, pending request tracking, ACK timer and retry control.
//------------------------------------------------------------------------------
`default_nettype none

module sfle_core (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cfg_we,
  input  wire logic            cfg_index,
  input  wire logic [15:0]     cfg_wdata,
  input  wire sfle_pkg::item_t item,
  input  wire logic            fire,
  output logic                 has_res,
  output sfle_pkg::res_t       res
);

  logic [15:0] timeout_r;
  logic [2:0]  max_att_r;

  sfle_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [7:0]  left_r, left_nxt;
  logic [7:0]  chk_r, chk_nxt;
  logic [7:0]  kind_r, kind_nxt;
  logic [7:0]  func_r, func_nxt;
  logic [7:0]  first_r, first_nxt;
  logic        pv_r, pv_nxt;
  logic [7:0]  pfunc_r, pfunc_nxt;
  logic        pcb_r, pcb_nxt;
  logic [7:0]  pid_r, pid_nxt;
  logic [7:0]  next_id_r, next_id_nxt;
  logic [2:0]  att_r, att_nxt;
  logic        armed_r, armed_nxt;
  logic [15:0] count_r, count_nxt;

  logic [7:0] b;
  logic [7:0] pos;
  logic [3:0] n_att;
  logic       can_retry;
  logic       is_resp;
  logic       has_payload;
  logic       match;
  logic       is_cb;
  logic       do_launch;
  logic       launch_cb;

  assign b           = item.rx_byte;
  assign pos         = len_r - sfle_pkg::LEN_OVERHEAD - left_r;
  assign n_att       = {1'b0, att_r} + 4'd1;
  assign can_retry   = n_att < {1'b0, max_att_r};
  assign is_resp     = kind_r == sfle_pkg::KIND_RESPONSE;
  assign has_payload = len_r >= sfle_pkg::MIN_PAYLOAD_LEN;
  assign match       = pv_r && (pfunc_r == func_r);
  assign is_cb       = (kind_r == sfle_pkg::KIND_REQUEST) && pcb_r && has_payload &&
                       (pid_r == first_r);

  always_comb begin
    phase_nxt   = phase_r;
    len_nxt     = len_r;
    left_nxt    = left_r;
    chk_nxt     = chk_r;
    kind_nxt    = kind_r;
    func_nxt    = func_r;
    first_nxt   = first_r;
    pv_nxt      = pv_r;
    pfunc_nxt   = pfunc_r;
    pcb_nxt     = pcb_r;
    pid_nxt     = pid_r;
    next_id_nxt = next_id_r;
    att_nxt     = att_r;
    armed_nxt   = armed_r;
    count_nxt   = count_r;
    do_launch   = 1'b0;
    launch_cb   = pcb_r;
    has_res     = 1'b0;
    res.event_res         = sfle_pkg::EV_BODY;
    res.data_byte         = '0;
    res.position          = '0;
    res.frame_is_response = 1'b0;
    res.func_id           = '0;

    unique case (item.req_type)
      sfle_pkg::REQ_BYTE: begin
        has_res = 1'b1;
        unique case (phase_r)
          sfle_pkg::PH_LEN: begin
            chk_nxt = chk_r ^ b;
            len_nxt = b;
            if (b < sfle_pkg::MIN_FRAME_LEN) begin
              phase_nxt     = sfle_pkg::PH_IDLE;
              res.event_res = sfle_pkg::EV_BAD_FRAME;
            end else begin
              phase_nxt = sfle_pkg::PH_TYPE;
              has_res   = 1'b0;
            end
          end
          sfle_pkg::PH_TYPE: begin
            chk_nxt   = chk_r ^ b;
            kind_nxt  = b;
            left_nxt  = len_r - sfle_pkg::LEN_OVERHEAD;
            phase_nxt = sfle_pkg::PH_BODY;
            has_res   = 1'b0;
          end
          sfle_pkg::PH_BODY: begin
            if (pos == 8'd0) begin
              func_nxt = b;
            end else if (pos == 8'd1) begin
              first_nxt = b;
            end
            chk_nxt  = chk_r ^ b;
            left_nxt = left_r - 8'd1;
            if (left_r == 8'd1) begin
              phase_nxt = sfle_pkg::PH_CHECK;
            end
            res.event_res         = sfle_pkg::EV_BODY;
            res.data_byte         = b;
            res.position          = pos;
            res.frame_is_response = is_resp;
          end
          sfle_pkg::PH_CHECK: begin
            phase_nxt             = sfle_pkg::PH_IDLE;
            res.frame_is_response = is_resp;
            if (b != chk_r) begin
              res.event_res = sfle_pkg::EV_BAD_FRAME;
            end else if (match) begin
              if ((is_resp && !pcb_r) || is_cb) begin
                armed_nxt = 1'b0;
                att_nxt   = '0;
                pv_nxt    = 1'b0;
              end
              if (is_resp) begin
                res.event_res = pcb_r ? sfle_pkg::EV_RESP_AWAIT_CB : sfle_pkg::EV_RESP_DONE;
              end else if (is_cb) begin
                res.event_res = sfle_pkg::EV_CB_DONE;
              end else begin
                res.event_res = sfle_pkg::EV_IGNORED;
              end
            end else begin
              res.event_res = (kind_r == sfle_pkg::KIND_REQUEST) ?
                              sfle_pkg::EV_UNSOLICITED : sfle_pkg::EV_IGNORED;
            end
          end
          default: begin
            phase_nxt = sfle_pkg::PH_IDLE;
            priority if (b == sfle_pkg::CODE_SOF) begin
              chk_nxt   = sfle_pkg::CHECK_INIT;
              len_nxt   = '0;
              kind_nxt  = '0;
              func_nxt  = '0;
              first_nxt = '0;
              left_nxt  = '0;
              phase_nxt = sfle_pkg::PH_LEN;
              has_res   = 1'b0;
            end else if (b == sfle_pkg::CODE_ACK) begin
              armed_nxt     = 1'b0;
              att_nxt       = '0;
              res.event_res = sfle_pkg::EV_ACK;
            end else if (b == sfle_pkg::CODE_NACK) begin
              armed_nxt     = 1'b0;
              res.event_res = sfle_pkg::EV_IGNORED;
              if (pv_r) begin
                if (can_retry) begin
                  att_nxt       = n_att[2:0];
                  do_launch     = 1'b1;
                  res.event_res = sfle_pkg::EV_RESEND;
                end else begin
                  att_nxt       = '0;
                  pv_nxt        = 1'b0;
                  res.event_res = sfle_pkg::EV_GIVEUP_NACK;
                end
              end
            end else if (b == sfle_pkg::CODE_CAN) begin
              res.event_res = sfle_pkg::EV_CAN;
            end else begin
              res.event_res = sfle_pkg::EV_UNKNOWN;
            end
          end
        endcase
      end
      sfle_pkg::REQ_SUBMIT: begin
        has_res = 1'b1;
        if (pv_r) begin
          res.event_res = sfle_pkg::EV_BUSY;
        end else begin
          pv_nxt        = 1'b1;
          pfunc_nxt     = item.req_function;
          pcb_nxt       = item.req_wants_callback;
          pid_nxt       = '0;
          att_nxt       = '0;
          launch_cb     = item.req_wants_callback;
          do_launch     = 1'b1;
          res.event_res = sfle_pkg::EV_ACCEPTED;
        end
      end
      sfle_pkg::REQ_TICK: begin
        if (armed_r) begin
          if (count_r > 16'd1) begin
            count_nxt = count_r - 16'd1;
          end else begin
            armed_nxt = 1'b0;
            count_nxt = '0;
            if (pv_r) begin
              has_res = 1'b1;
              if (can_retry) begin
                att_nxt       = n_att[2:0];
                do_launch     = 1'b1;
                res.event_res = sfle_pkg::EV_RESEND;
              end else begin
                att_nxt       = '0;
                pv_nxt        = 1'b0;
                res.event_res = sfle_pkg::EV_GIVEUP_TIMEOUT;
              end
            end
          end
        end
      end
      default: begin
      end
    endcase

    if (do_launch) begin
      armed_nxt = 1'b1;
      count_nxt = timeout_r;
      if (launch_cb) begin
        res.func_id = next_id_r;
        pid_nxt     = next_id_r;
        next_id_nxt = (next_id_r == sfle_pkg::ID_LAST) ? sfle_pkg::ID_FIRST : next_id_r + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= sfle_pkg::PH_IDLE;
      len_r     <= '0;
      left_r    <= '0;
      chk_r     <= sfle_pkg::CHECK_INIT;
      kind_r    <= '0;
      func_r    <= '0;
      first_r   <= '0;
      pv_r      <= 1'b0;
      pfunc_r   <= '0;
      pcb_r     <= 1'b0;
      pid_r     <= '0;
      next_id_r <= sfle_pkg::ID_FIRST;
      att_r     <= '0;
      armed_r   <= 1'b0;
      count_r   <= '0;
    end else if (fire) begin
      phase_r   <= phase_nxt;
      len_r     <= len_nxt;
      left_r    <= left_nxt;
      chk_r     <= chk_nxt;
      kind_r    <= kind_nxt;
      func_r    <= func_nxt;
      first_r   <= first_nxt;
      pv_r      <= pv_nxt;
      pfunc_r   <= pfunc_nxt;
      pcb_r     <= pcb_nxt;
      pid_r     <= pid_nxt;
      next_id_r <= next_id_nxt;
      att_r     <= att_nxt;
      armed_r   <= armed_nxt;
      count_r   <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= sfle_pkg::ACK_TIMEOUT_RST;
      max_att_r <= sfle_pkg::MAX_ATTEMPTS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sfle_pkg::CFG_ACK_TIMEOUT:  timeout_r <= cfg_wdata;
        sfle_pkg::CFG_MAX_ATTEMPTS: max_att_r <= cfg_wdata[2:0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/sfle_out_stage.sv =====
//------------------------------------------------------------------------------
// sfle_out_stage
// Result register: holds one result until the receiver takes it.
//------------------------------------------------------------------------------
`default_nettype none

module sfle_out_stage (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           load,
  input  wire sfle_pkg::res_t res,
  output logic                room,
  output logic                out_valid,
  input  wire logic           out_stall,
  output sfle_pkg::res_t      out_res
);

  logic           valid_r;
  logic           valid_nxt;
  sfle_pkg::res_t res_r;

  assign room      = !valid_r || !out_stall;
  assign valid_nxt = load ? 1'b1 : (valid_r && out_stall);
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule

`default_nettype wire

// ===== sv/serial_frame_link_engine.sv =====
//------------------------------------------------------------------------------
// serial_frame_link_engine
// Host-side serial frame link: frame parsing, ACK/NACK/CAN handling,
// ACK timeout, retries and callback id assignment.
//------------------------------------------------------------------------------
//  port group  direction  handshake          payload
//  in_*        input      in_valid/in_stall  req_type, rx_byte, req_function,
//                                            req_wants_callback
//  out_*       output     out_valid/out_stall event_res, data_byte, position,
//                                            frame_is_response, func_id
//  cfg_*       input      cfg_we             cfg_index, cfg_wdata
//
//  One item per cycle sustained while the receiver takes results; a result
//  passes the input register, then the result register.
//  Each item updates the link state in the core logic between the registers.
//  Reset is synchronous; no sweep, the block is ready in the next cycle.
//  A stalled result holds its register; items that give no result keep moving.
//------------------------------------------------------------------------------
`default_nettype none

module serial_frame_link_engine (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [7:0]  in_rx_byte,
  input  wire logic [7:0]  in_req_function,
  input  wire logic        in_req_wants_callback,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       out_event_res,
  output logic [7:0]       out_data_byte,
  output logic [7:0]       out_position,
  output logic             out_frame_is_response,
  output logic [7:0]       out_func_id,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  sfle_pkg::item_t in_item;
  sfle_pkg::item_t item;
  sfle_pkg::res_t  res;
  sfle_pkg::res_t  out_res;
  logic            item_valid;
  logic            has_res;
  logic            room;
  logic            fire;

  assign in_item.req_type           = in_req_type;
  assign in_item.rx_byte            = in_rx_byte;
  assign in_item.req_function       = in_req_function;
  assign in_item.req_wants_callback = in_req_wants_callback;

  assign fire = item_valid && (!has_res || room);

  sfle_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .consume    (fire),
    .item_valid (item_valid),
    .item       (item)
  );

  sfle_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .item      (item),
    .fire      (fire),
    .has_res   (has_res),
    .res       (res)
  );

  sfle_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire && has_res),
    .res       (res),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_event_res         = out_res.event_res;
  assign out_data_byte         = out_res.data_byte;
  assign out_position          = out_res.position;
  assign out_frame_is_response = out_res.frame_is_response;
  assign out_func_id           = out_res.func_id;

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> item_valid && has_res && !room)
    else $error("input stalled without a blocked result");

  a_rose_from_fire: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(fire && has_res))
    else $error("result appeared without a transfer from the core");

  a_body_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_res == sfle_pkg::EV_BODY) |-> out_func_id == 8'd0)
    else $error("body byte carries a function id");

  a_non_body_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_res != sfle_pkg::EV_BODY)
      |-> (out_data_byte == 8'd0) && (out_position == 8'd0))
    else $error("non-body result carries body data");

endmodule

`default_nettype wire

// ===== tb/sv/serial_frame_link_engine_tb.sv =====
//------------------------------------------------------------------------------
// serial_frame_link_engine_tb
// Self-checking bench for the serial frame link engine. A scoreboard class
// tracks parser and request state, predicts the result, if any, for every input
// transfer and compares each result transfer field by field. Stimulus mixes
// well-formed request/response/callback exchanges, ACK/NACK/CAN bytes, timer
// ticks, broken frames and noise over several timeout and retry settings,
// with random sender gaps and receiver stalls.
//------------------------------------------------------------------------------
`timescale 1ns / 100ps

class link_scoreboard;
  logic [15:0]       ack_ticks;
  logic [2:0]        attempt_limit;
  sfle_pkg::phase_t  phase;
  logic [7:0]        flen, left, chk, fkind, ffunc, fpay;
  bit                req_live, req_cb, tmr_on;
  logic [7:0]        req_func, req_id, id_next;
  logic [2:0]        tries;
  logic [15:0]       tmr;
  sfle_pkg::res_t    link_events_q[$];
  int                errors, noted, checked;
  bit                ev_seen[16];

  function new();
    ack_ticks = sfle_pkg::ACK_TIMEOUT_RST;
    attempt_limit = sfle_pkg::MAX_ATTEMPTS_RST;
    phase = sfle_pkg::PH_IDLE;
    flen = 8'd0;
    left = 8'd0;
    chk = sfle_pkg::CHECK_INIT;
    fkind = 8'd0;
    ffunc = 8'd0;
    fpay = 8'd0;
    req_live = 1'b0;
    req_cb = 1'b0;
    req_func = 8'd0;
    req_id = 8'd0;
    id_next = sfle_pkg::ID_FIRST;
    tries = 3'd0;
    tmr_on = 1'b0;
    tmr = 16'd0;
  endfunction

  function void configure(logic [15:0] ticks, logic [2:0] limit);
    ack_ticks = ticks;
    attempt_limit = limit;
  endfunction

  function void push(sfle_pkg::ev_t ev, logic [7:0] data, logic [7:0] pos, logic resp,
                     logic [7:0] id);
    sfle_pkg::res_t r;
    r.event_res = ev;
    r.data_byte = data;
    r.position = pos;
    r.frame_is_response = resp;
    r.func_id = id;
    link_events_q.insert(link_events_q.size(), r);
  endfunction

  function logic [7:0] launch_req();
    logic [7:0] id;
    id = 8'd0;
    if (req_cb) begin
      id = id_next;
      req_id = id_next;
      id_next = (id_next < sfle_pkg::ID_LAST) ? id_next + 8'd1 : sfle_pkg::ID_FIRST;
    end
    tmr_on = 1'b1;
    tmr = ack_ticks;
    return id;
  endfunction

  function sfle_pkg::ev_t retry_req(sfle_pkg::ev_t giveup, output logic [7:0] id);
    id = 8'd0;
    if (int'(tries) + 1 < int'(attempt_limit)) begin
      tries = tries + 3'd1;
      id = launch_req();
      return sfle_pkg::EV_RESEND;
    end
    tries = 3'd0;
    req_live = 1'b0;
    tmr_on = 1'b0;
    return giveup;
  endfunction

  function void note_transfer(logic [1:0] rtype, logic [7:0] rx, logic [7:0] fn,
                              logic cb);
    logic [7:0]    id;
    logic [7:0]    pos;
    logic          resp;
    bit            is_resp, is_cb;
    sfle_pkg::ev_t ev;
    id = 8'd0;
    noted++;
    if (rtype == sfle_pkg::REQ_BYTE) begin
      resp = (fkind == sfle_pkg::KIND_RESPONSE);
      case (phase)
        sfle_pkg::PH_LEN: begin
          chk ^= rx;
          flen = rx;
          if (rx < sfle_pkg::MIN_FRAME_LEN) begin
            phase = sfle_pkg::PH_IDLE;
            push(sfle_pkg::EV_BAD_FRAME, 8'd0, 8'd0, 1'b0, 8'd0);
          end else begin
            phase = sfle_pkg::PH_TYPE;
          end
        end
        sfle_pkg::PH_TYPE: begin
          chk ^= rx;
          fkind = rx;
          left = flen - sfle_pkg::LEN_OVERHEAD;
          phase = sfle_pkg::PH_BODY;
        end
        sfle_pkg::PH_BODY: begin
          pos = flen - sfle_pkg::LEN_OVERHEAD - left;
          if (pos == 8'd0) ffunc = rx;
          else if (pos == 8'd1) fpay = rx;
          chk ^= rx;
          left = left - 8'd1;
          if (left == 8'd0) phase = sfle_pkg::PH_CHECK;
          push(sfle_pkg::EV_BODY, rx, pos, resp, 8'd0);
        end
        sfle_pkg::PH_CHECK: begin
          phase = sfle_pkg::PH_IDLE;
          if (rx != chk) begin
            push(sfle_pkg::EV_BAD_FRAME, 8'd0, 8'd0, resp, 8'd0);
          end else begin
            is_resp = (fkind == sfle_pkg::KIND_RESPONSE);
            if (req_live && req_func == ffunc) begin
              is_cb = fkind == sfle_pkg::KIND_REQUEST && req_cb &&
                      flen >= sfle_pkg::MIN_PAYLOAD_LEN && req_id == fpay;
              if ((is_resp && !req_cb) || is_cb) begin
                tmr_on = 1'b0;
                tries = 3'd0;
                req_live = 1'b0;
              end
              if (is_resp)
                ev = req_cb ? sfle_pkg::EV_RESP_AWAIT_CB : sfle_pkg::EV_RESP_DONE;
              else if (is_cb) ev = sfle_pkg::EV_CB_DONE;
              else ev = sfle_pkg::EV_IGNORED;
            end else begin
              ev = (fkind == sfle_pkg::KIND_REQUEST) ? sfle_pkg::EV_UNSOLICITED :
                                                       sfle_pkg::EV_IGNORED;
            end
            push(ev, 8'd0, 8'd0, resp, 8'd0);
          end
        end
        default: begin
          phase = sfle_pkg::PH_IDLE;
          if (rx == sfle_pkg::CODE_SOF) begin
            chk = sfle_pkg::CHECK_INIT;
            flen = 8'd0;
            fkind = 8'd0;
            ffunc = 8'd0;
            fpay = 8'd0;
            left = 8'd0;
            phase = sfle_pkg::PH_LEN;
          end else if (rx == sfle_pkg::CODE_ACK) begin
            tmr_on = 1'b0;
            tries = 3'd0;
            push(sfle_pkg::EV_ACK, 8'd0, 8'd0, 1'b0, 8'd0);
          end else if (rx == sfle_pkg::CODE_NACK) begin
            tmr_on = 1'b0;
            ev = sfle_pkg::EV_IGNORED;
            if (req_live) ev = retry_req(sfle_pkg::EV_GIVEUP_NACK, id);
            push(ev, 8'd0, 8'd0, 1'b0, id);
          end else if (rx == sfle_pkg::CODE_CAN) begin
            push(sfle_pkg::EV_CAN, 8'd0, 8'd0, 1'b0, 8'd0);
          end else begin
            push(sfle_pkg::EV_UNKNOWN, 8'd0, 8'd0, 1'b0, 8'd0);
          end
        end
      endcase
    end else if (rtype == sfle_pkg::REQ_SUBMIT) begin
      if (req_live) begin
        push(sfle_pkg::EV_BUSY, 8'd0, 8'd0, 1'b0, 8'd0);
      end else begin
        req_live = 1'b1;
        req_func = fn;
        req_cb = cb;
        req_id = 8'd0;
        tries = 3'd0;
        id = launch_req();
        push(sfle_pkg::EV_ACCEPTED, 8'd0, 8'd0, 1'b0, id);
      end
    end else if (rtype == sfle_pkg::REQ_TICK && tmr_on) begin
      if (tmr > 16'd1) begin
        tmr = tmr - 16'd1;
      end else begin
        tmr_on = 1'b0;
        tmr = 16'd0;
        if (req_live) begin
          ev = retry_req(sfle_pkg::EV_GIVEUP_TIMEOUT, id);
          push(ev, 8'd0, 8'd0, 1'b0, id);
        end
      end
    end
  endfunction

  function void field_check(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      errors++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  function void check_result(logic [3:0] ev, logic [7:0] data, logic [7:0] pos,
                             logic resp, logic [7:0] id);
    sfle_pkg::res_t want;
    if (link_events_q.size() == 0) begin
      errors++;
      $error("result with nothing expected: event_res %0d", ev);
      return;
    end
    want = link_events_q[0];
    link_events_q.delete(0);
    checked++;
    ev_seen[want.event_res] = 1'b1;
    field_check("event_res", 8'(want.event_res), 8'(ev));
    field_check("data_byte", want.data_byte, data);
    field_check("position", want.position, pos);
    field_check("frame_is_response", 8'(want.frame_is_response), 8'(resp));
    field_check("func_id", want.func_id, id);
  endfunction

  function int outstanding();
    return link_events_q.size();
  endfunction
endclass

module serial_frame_link_engine_tb;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS   = 1330;
  localparam int N_SETTINGS     = 8;
  localparam int LATENCY        = 2;
  localparam int SETTLE_CYCLES  = LATENCY + 4;
  localparam int HOLD_CYCLES    = 150;
  localparam int DRAIN_LIMIT    = 3000;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam logic [15:0] TICK_SET [6] = '{16'd1, 16'd65535, 16'd4, 16'd2, 16'd9, 16'd1};
  localparam logic [2:0]  TRY_SET  [6] = '{3'd1, 3'd7, 3'd3, 3'd7, 3'd2, 3'd5};

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_req_type;
  logic [7:0]  in_rx_byte;
  logic [7:0]  in_req_function;
  logic        in_req_wants_callback;
  logic        out_valid;
  logic        out_stall;
  logic [3:0]  out_event_res;
  logic [7:0]  out_data_byte;
  logic [7:0]  out_position;
  logic        out_frame_is_response;
  logic [7:0]  out_func_id;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_wdata;

  link_scoreboard sb;
  int          items_sent;
  int          burst_left;
  int          quiet_cycles;
  int          cur_ticks;
  int          cur_tries;
  bit          hold_req;

  serial_frame_link_engine uut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_req_type           (in_req_type),
    .in_rx_byte            (in_rx_byte),
    .in_req_function       (in_req_function),
    .in_req_wants_callback (in_req_wants_callback),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_event_res         (out_event_res),
    .out_data_byte         (out_data_byte),
    .out_position          (out_position),
    .out_frame_is_response (out_frame_is_response),
    .out_func_id           (out_func_id),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // receiver: changing stall patterns, plus long hold-offs on request
  initial begin
    int span, mode, k;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(4, 60);
        for (k = 0; k < span && !hold_req; k++) begin
          case (mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 9) < 7);
            default: out_stall <= k[0];
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // result checking and watchdog
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_event_res, out_data_byte, out_position,
                      out_frame_is_response, out_func_id);
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("serial_frame_link_engine regression: fail");
        $finish;
      end
    end
  end

  task automatic send(logic [1:0] rtype, logic [7:0] rx, logic [7:0] fn, logic cb);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_req_type <= rtype;
    in_rx_byte <= rx;
    in_req_function <= fn;
    in_req_wants_callback <= cb;
    do @(posedge clk); while (in_stall);
    sb.note_transfer(rtype, rx, fn, cb);
    if (rtype != REQ_UNUSED) items_sent++;
  endtask

  task automatic send_byte(logic [7:0] b);
    send(sfle_pkg::REQ_BYTE, b, 8'($urandom), 1'($urandom));
  endtask

  task automatic send_tick();
    send(sfle_pkg::REQ_TICK, 8'($urandom), 8'($urandom), 1'($urandom));
  endtask

  task automatic send_frame(logic [7:0] kind, logic [7:0] fn, int npay,
                            logic [7:0] first, bit bad);
    logic [7:0] body[$];
    logic [7:0] sum;
    int k;
    body.insert(body.size(), 8'(npay + 3));
    body.insert(body.size(), kind);
    body.insert(body.size(), fn);
    for (k = 0; k < npay; k++)
      body.insert(body.size(), (k == 0) ? first : 8'($urandom));
    sum = sfle_pkg::CHECK_INIT;
    for (k = 0; k < body.size(); k++) sum ^= body[k];
    if (bad) sum ^= 8'($urandom_range(1, 255));
    body.insert(body.size(), sum);
    send_byte(sfle_pkg::CODE_SOF);
    for (k = 0; k < body.size(); k++) begin
      if ($urandom_range(0, 19) == 0) send_tick();
      else if ($urandom_range(0, 79) == 0)
        send(sfle_pkg::REQ_SUBMIT, 8'($urandom), 8'($urandom), 1'($urandom));
      send_byte(body[k]);
    end
  endtask

  task automatic set_link_config(logic [15:0] ticks, logic [2:0] limit);
    cfg_we <= 1'b1;
    cfg_index <= sfle_pkg::CFG_ACK_TIMEOUT;
    cfg_wdata <= ticks;
    @(posedge clk);
    cfg_index <= sfle_pkg::CFG_MAX_ATTEMPTS;
    cfg_wdata <= {13'($urandom), limit};
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.configure(ticks, limit);
    cur_ticks = ticks;
    cur_tries = limit;
  endtask

  task automatic drain();
    int k;
    in_valid <= 1'b0;
    @(posedge clk);
    for (k = 0; k < DRAIN_LIMIT && sb.outstanding() != 0; k++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int p, scene, k, n, r, kinds;
    logic [7:0] fn, kind;
    logic cb;
    logic [15:0] ticks_set;
    logic [2:0] tries_set;
    sb = new();
    items_sent = 0;
    burst_left = 0;
    quiet_cycles = 0;
    hold_req = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_req_type <= sfle_pkg::REQ_BYTE;
    in_rx_byte <= 8'h00;
    in_req_function <= 8'h00;
    in_req_wants_callback <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= sfle_pkg::CFG_ACK_TIMEOUT;
    cfg_wdata <= 16'h0000;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: byte codes, short length, busy, NACK and timeout retries
    set_link_config(16'd1, 3'd2);
    send_tick();
    send(REQ_UNUSED, 8'hFF, 8'hFF, 1'b1);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(sfle_pkg::CODE_CAN);
    send_byte(sfle_pkg::CODE_ACK);
    send_byte(sfle_pkg::CODE_NACK);
    send_byte(sfle_pkg::CODE_SOF);
    send_byte(8'h02);
    send(sfle_pkg::REQ_SUBMIT, 8'h00, 8'hFF, 1'b1);
    send(sfle_pkg::REQ_SUBMIT, 8'hFF, 8'h00, 1'b0);
    send_byte(sfle_pkg::CODE_NACK);
    send_byte(sfle_pkg::CODE_NACK);
    send(sfle_pkg::REQ_SUBMIT, 8'hFF, 8'h00, 1'b0);
    send_tick();
    send_tick();
    send_frame(sfle_pkg::KIND_REQUEST, 8'h7E, 0, 8'h00, 1'b0);
    drain();

    for (p = 0; p < N_SETTINGS; p++) begin
      if (p < 6) begin
        ticks_set = TICK_SET[p];
        tries_set = TRY_SET[p];
      end else begin
        ticks_set = 16'($urandom_range(1, 40));
        tries_set = 3'($urandom_range(1, 7));
      end
      set_link_config(ticks_set, tries_set);
      if (p == 2 || p == 5) hold_req = 1'b1;
      if (p == 3)
        send_frame(sfle_pkg::KIND_RESPONSE, 8'($urandom), 252, 8'($urandom), 1'b0);
      while (items_sent < 21 + (p + 1) * RANDOM_ITEMS / N_SETTINGS) begin
        scene = $urandom_range(0, 99);
        if (scene < 45) begin
          fn = 8'($urandom);
          cb = 1'($urandom);
          send(sfle_pkg::REQ_SUBMIT, 8'($urandom), fn, cb);
          r = $urandom_range(0, 9);
          if (r == 5 || r == 6) begin
            n = $urandom_range(1, cur_tries);
            for (k = 0; k < n; k++) send_byte(sfle_pkg::CODE_NACK);
          end else if (r == 7 || r == 8) begin
            n = cur_ticks * cur_tries + 2;
            if (n > 80) n = $urandom_range(1, 80);
            for (k = 0; k < n; k++) send_tick();
          end
          if (r != 7 && $urandom_range(0, 3) != 0) send_byte(sfle_pkg::CODE_ACK);
          if (r == 9) begin
            if ($urandom_range(0, 1) == 0)
              send_frame(sfle_pkg::KIND_RESPONSE, fn ^ 8'($urandom_range(1, 255)),
                         $urandom_range(0, 4), 8'($urandom), 1'b0);
            else
              send_frame(sfle_pkg::KIND_REQUEST, fn, $urandom_range(0, 4),
                         sb.req_id ^ 8'($urandom_range(1, 255)), 1'b0);
          end else begin
            send_frame(sfle_pkg::KIND_RESPONSE, fn, $urandom_range(0, 5), 8'($urandom),
                       $urandom_range(0, 7) == 0);
            if (cb) begin
              n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
              send_frame(sfle_pkg::KIND_REQUEST, fn, n,
                         ($urandom_range(0, 4) == 0) ? 8'($urandom) : sb.req_id,
                         $urandom_range(0, 9) == 0);
            end
          end
          if (sb.req_live && $urandom_range(0, 1) == 0)
            while (sb.req_live) send_byte(sfle_pkg::CODE_NACK);
        end else if (scene < 60) begin
          n = $urandom_range(0, 6);
          if ($urandom_range(0, 149) == 0) n = 252;
          else if ($urandom_range(0, 9) == 0) n = $urandom_range(7, 40);
          kind = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 1));
          fn = (sb.req_live && $urandom_range(0, 1) == 0) ? sb.req_func : 8'($urandom);
          send_frame(kind, fn, n, 8'($urandom), $urandom_range(0, 5) == 0);
        end else if (scene < 70) begin
          send_byte(sfle_pkg::CODE_SOF);
          if ($urandom_range(0, 1) == 0) begin
            send_byte(8'($urandom_range(0, 2)));
          end else begin
            send_byte(8'($urandom));
            n = $urandom_range(0, 4);
            for (k = 0; k < n; k++) send_byte(8'($urandom));
          end
        end else if (scene < 85) begin
          case ($urandom_range(0, 3))
            0: send_byte(sfle_pkg::CODE_ACK);
            1: send_byte(sfle_pkg::CODE_NACK);
            2: send_byte(sfle_pkg::CODE_CAN);
            default: send_byte(8'($urandom));
          endcase
        end else if (scene < 95) begin
          n = $urandom_range(1, 12);
          for (k = 0; k < n; k++) send_tick();
        end else begin
          n = $urandom_range(1, 4);
          for (k = 0; k < n; k++)
            send(2'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
        end
      end
      drain();
    end

    if (sb.outstanding() != 0) begin
      $error("%0d expected results never arrived", sb.outstanding());
      sb.errors += sb.outstanding();
    end
    kinds = 0;
    for (k = 0; k < 15; k++) if (sb.ev_seen[k]) kinds++;
    $display("run covered %0d input transfers and %0d checked results over %0d settings",
             sb.noted, sb.checked, N_SETTINGS + 1);
    $display("event kinds seen: %0d of 15, mismatches: %0d", kinds, sb.errors);
    if (sb.errors == 0)
      $display("serial_frame_link_engine regression: pass");
    else
      $display("serial_frame_link_engine regression: fail");
    $finish;
  end

endmodule

// ===== serial_frame_link_engine.f =====
sv/sfle_pkg.sv
sv/sfle_in_stage.sv
sv/sfle_core.sv
sv/sfle_out_stage.sv
sv/serial_frame_link_engine.sv
tb/sv/serial_frame_link_engine_tb.sv
